@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL core of the cache tag block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/salc_pkg.sv @@
// Package with the types and constants of the set-associative LRU cache tag block.
`timescale 1ns / 1ps
package salc_pkg;

    // Geometry
    localparam int MAX_WAYS       = 8;
    localparam int MAX_INDEX_BITS = 10;
    localparam int ADDR_BITS      = 48;
    localparam int STAMP_W        = 64;
    localparam int COUNT_W        = 32;

    localparam int SET_COUNT = 1 << MAX_INDEX_BITS;
    localparam int SET_W     = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYS       = 2'd0,
        CFG_INDEX_BITS = 2'd1,
        CFG_OFFSET     = 2'd2,
        CFG_COUNT_EN   = 2'd3
    } t_cfg_idx;

    // One way of a set, and one whole set as a memory row
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] tag;
        logic [STAMP_W-1:0]   stamp;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

endpackage

@@ rtl/set_assoc_lru_cache_tags_core.sv @@
// Set-associative LRU cache tag store with hit and miss statistics.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_ready, i_address         | in
//  result   | o_out_valid, i_out_ready, o_hit,          | out
//           | o_hit_total, o_miss_total                 |
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// An item passes through ST_READ, which reads the set row from the tag
// memory, ST_SCAN, one way per step over tags and stamps (ways = effective
// way count, 1..8), ST_WRITE, which writes the row back, and ST_IDLE before
// the next accept. After reset a clearing pass writes every set row (SET_COUNT,
// 1024 rows) with o_in_ready low; configuration writes are taken during it.
// The write-back state holds while the result register is still full; the
// next item is accepted while a finished result waits to be taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module set_assoc_lru_cache_tags_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_W-1:0]       i_cfg_data,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [salc_pkg::ADDR_BITS-1:0]   i_address,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [salc_pkg::COUNT_W-1:0]     o_hit_total,
    output logic [salc_pkg::COUNT_W-1:0]     o_miss_total
);
    import salc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // Configuration registers
    logic [CFG_W-1:0] r_cfg_ways;
    logic [CFG_W-1:0] r_cfg_ibits;
    logic [CFG_W-1:0] r_cfg_offset;
    logic             r_cfg_count_en;

    // Control and item state
    t_state             r_state;
    logic [SET_W-1:0]   r_clr_idx;
    logic [SET_W-1:0]   r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic [WAY_W-1:0]   r_way;
    logic [WAY_W-1:0]   r_way_last;
    logic               r_hit_found;
    logic [WAY_W-1:0]   r_hit_way;
    logic               r_inv_found;
    logic [WAY_W-1:0]   r_victim;
    logic [STAMP_W-1:0] r_best;
    logic [STAMP_W-1:0] r_clock;
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_misses;

    // Result register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [COUNT_W-1:0] r_out_hit_total;
    logic [COUNT_W-1:0] r_out_miss_total;

    // Tag memory: one row per set
    t_row r_mem [SET_COUNT];
    t_row r_row;

    // Address split of the incoming item
    logic [CFG_W-1:0]     w_ibits;
    logic [CFG_W:0]       w_tag_shift;
    logic [ADDR_BITS-1:0] w_shifted;
    logic [SET_W-1:0]     w_set_mask;
    logic [SET_W-1:0]     w_set;
    logic [ADDR_BITS-1:0] w_tag;
    logic [WAY_W-1:0]     w_way_last;

    always_comb begin
        if (32'(r_cfg_ibits) > MAX_INDEX_BITS) begin
            w_ibits = CFG_W'(MAX_INDEX_BITS);
        end else begin
            w_ibits = r_cfg_ibits;
        end
        w_tag_shift = {1'b0, r_cfg_offset} + {1'b0, w_ibits};
        w_shifted   = i_address >> r_cfg_offset;
        w_set_mask  = ~({SET_W{1'b1}} << w_ibits);
        w_set       = w_shifted[SET_W-1:0] & w_set_mask;
        w_tag       = i_address >> w_tag_shift;
        if (r_cfg_ways == '0) begin
            w_way_last = '0;
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            w_way_last = WAY_W'(MAX_WAYS - 1);
        end else begin
            w_way_last = WAY_W'(r_cfg_ways - 1'b1);
        end
    end

    // Scan step over one way of the row
    t_line w_line;
    logic  w_tag_match;
    logic  w_older;
    logic  w_fire_in;
    logic  w_slot_free;
    logic  w_commit;

    assign w_line      = r_row[r_way];
    assign w_tag_match = w_line.valid && (w_line.tag == r_tag);
    assign w_older     = (r_way == '0) || (w_line.stamp < r_best);
    assign w_fire_in   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == ST_WRITE) && w_slot_free;

    // Row to write back: refresh the hit way or fill the victim
    logic [WAY_W-1:0] w_sel;
    t_row             w_new_row;
    logic             w_mem_we;
    logic [SET_W-1:0] w_mem_addr;
    t_row             w_mem_data;

    always_comb begin
        w_sel     = r_hit_found ? r_hit_way : r_victim;
        w_new_row = r_row;
        w_new_row[w_sel].stamp = r_clock;
        if (!r_hit_found) begin
            w_new_row[w_sel].valid = 1'b1;
            w_new_row[w_sel].tag   = r_tag;
        end
        w_mem_we   = (r_state == ST_CLEAR) || w_commit;
        w_mem_addr = (r_state == ST_CLEAR) ? r_clr_idx : r_set;
        w_mem_data = (r_state == ST_CLEAR) ? '0 : w_new_row;
    end

    // Write one row and read the set row of the current item
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_data;
        end
        if (r_state == ST_READ) begin
            r_row <= r_mem[r_set];
        end
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ways     <= CFG_W'(8);
            r_cfg_ibits    <= CFG_W'(6);
            r_cfg_offset   <= CFG_W'(7);
            r_cfg_count_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WAYS:       r_cfg_ways     <= i_cfg_data;
                CFG_INDEX_BITS: r_cfg_ibits    <= i_cfg_data;
                CFG_OFFSET:     r_cfg_offset   <= i_cfg_data;
                CFG_COUNT_EN:   r_cfg_count_en <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Advance the sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_clock     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken result unless a new one lands in the same cycle
            if (r_out_valid && i_out_ready && !w_commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (32'(r_clr_idx) == SET_COUNT - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_fire_in) begin
                        r_set      <= w_set;
                        r_tag      <= w_tag;
                        r_way_last <= w_way_last;
                        r_state    <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_way       <= '0;
                    r_hit_found <= 1'b0;
                    r_inv_found <= 1'b0;
                    r_victim    <= '0;
                    r_best      <= '0;
                    r_state     <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (!r_hit_found && w_tag_match) begin
                        r_hit_found <= 1'b1;
                        r_hit_way   <= r_way;
                    end
                    // first empty way wins; else lowest way with the oldest stamp
                    if (!r_inv_found) begin
                        if (!w_line.valid) begin
                            r_inv_found <= 1'b1;
                            r_victim    <= r_way;
                        end else if (w_older) begin
                            r_best   <= w_line.stamp;
                            r_victim <= r_way;
                        end
                    end
                    r_way <= r_way + 1'b1;
                    if (r_way == r_way_last) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (w_slot_free) begin
                        r_clock     <= r_clock + 1'b1;
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit_found;
                        // saturate the counter of this outcome
                        if (r_cfg_count_en && r_hit_found && (r_hits != '1)) begin
                            r_hits          <= r_hits + 1'b1;
                            r_out_hit_total <= r_hits + 1'b1;
                        end else begin
                            r_out_hit_total <= r_hits;
                        end
                        if (r_cfg_count_en && !r_hit_found && (r_misses != '1)) begin
                            r_misses         <= r_misses + 1'b1;
                            r_out_miss_total <= r_misses + 1'b1;
                        end else begin
                            r_out_miss_total <= r_misses;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_hit_total  = r_out_hit_total;
    assign o_miss_total = r_out_miss_total;

    // Checks
    `ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, w_fire_in, r_state == ST_READ)
    `ASSERT_SAME(a_one_counter, i_clk, i_rst_n, $past(i_rst_n),
        !((r_hits != $past(r_hits)) && (r_misses != $past(r_misses))))
    `ASSERT_SAME(a_hits_step, i_clk, i_rst_n, $past(i_rst_n) && (r_hits != $past(r_hits)),
        r_hits == $past(r_hits) + 1'b1)
    `ASSERT_SAME(a_result_from_write, i_clk, i_rst_n, $past(i_rst_n) && $rose(r_out_valid),
        $past(r_state) == ST_WRITE)

endmodule

@@ test/set_assoc_lru_cache_tags_core_tb.sv @@
// Testbench for the LRU cache tag core: directed table and random trace checked by a predictor.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_core_tb;
    import salc_pkg::*;

    localparam int LINES       = SET_COUNT * MAX_WAYS;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int PLAN_ROWS   = 27;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
    } lookup_t;

    typedef enum logic {ROW_CFG, ROW_ACC} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        t_cfg_idx             reg_sel;
        logic [CFG_W-1:0]     data;
        logic [ADDR_BITS-1:0] addr;
        bit                   typed;
        lookup_t              want;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ADDR_BITS-1:0] i_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_hit;
    logic [COUNT_W-1:0]   o_hit_total;
    logic [COUNT_W-1:0]   o_miss_total;

    // Shadow tag store, access clock and statistics
    bit                   shadow_valid [LINES];
    bit [ADDR_BITS-1:0]   shadow_tag   [LINES];
    bit [63:0]            shadow_stamp [LINES];
    bit [63:0]            access_tick;
    bit [COUNT_W-1:0]     hits_n;
    bit [COUNT_W-1:0]     misses_n;
    bit [3:0]             cfg_ways;
    bit [3:0]             cfg_ibits;
    bit [3:0]             cfg_offset;
    bit                   cfg_count;

    lookup_t              pending_lookups [$];
    int                   err_count;
    int                   rx_count;
    plan_row_t            plan [PLAN_ROWS];

    set_assoc_lru_cache_tags_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_address    (i_address),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Look up one address in the shadow store and update it like the block does
    function automatic lookup_t predict_lookup(input logic [ADDR_BITS-1:0] addr);
        int      ways;
        int      ibits;
        int      base;
        int      w;
        int      victim;
        bit      found;
        bit [63:0] set_sel;
        bit [63:0] best;
        bit [ADDR_BITS-1:0] tag;
        lookup_t r;
        ways  = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
        ibits = (cfg_ibits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(cfg_ibits);
        set_sel = (64'(addr) >> cfg_offset) & ((64'd1 << ibits) - 64'd1);
        tag     = ADDR_BITS'(64'(addr) >> (cfg_offset + ibits));
        base    = int'(set_sel) * MAX_WAYS;
        found   = 1'b0;
        victim  = 0;
        for (w = 0; w < ways; w++) begin
            if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                found  = 1'b1;
                victim = w;
            end
        end
        if (found) begin
            shadow_stamp[base + victim] = access_tick;
            if (cfg_count && hits_n != '1) hits_n++;
        end else begin
            // first empty way wins, else lowest-numbered oldest stamp
            best = shadow_stamp[base];
            for (w = 0; w < ways; w++) begin
                if (!shadow_valid[base + w]) begin
                    victim = w;
                    break;
                end
                if (shadow_stamp[base + w] < best) begin
                    best   = shadow_stamp[base + w];
                    victim = w;
                end
            end
            shadow_valid[base + victim] = 1'b1;
            shadow_tag[base + victim]   = tag;
            shadow_stamp[base + victim] = access_tick;
            if (cfg_count && misses_n != '1) misses_n++;
        end
        access_tick++;
        r.hit        = found;
        r.hit_total  = hits_n;
        r.miss_total = misses_n;
        return r;
    endfunction

    // Offer one address, wait for the accept, then queue its expected lookup
    task automatic put_access(input logic [ADDR_BITS-1:0] addr, input int gap,
                              input bit typed, input lookup_t want);
        lookup_t r;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        r = predict_lookup(addr);
        pending_lookups.push_back(typed ? want : r);
    endtask

    // Drop valid and wait until every queued lookup has come back
    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (sel)
            CFG_WAYS:       cfg_ways   = data;
            CFG_INDEX_BITS: cfg_ibits  = data;
            CFG_OFFSET:     cfg_offset = data;
            CFG_COUNT_EN:   cfg_count  = data[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: random stalls, two long hold-offs, compare each result
    initial begin : result_side
        int      stall_left;
        bit      held_first;
        bit      held_second;
        lookup_t want;
        stall_left  = 0;
        held_first  = 1'b0;
        held_second = 1'b0;
        rx_count    = 0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (o_out_valid && i_out_ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result item with nothing expected: hit=%0d", o_hit);
                    err_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        err_count++;
                    end
                    if (o_hit_total !== want.hit_total) begin
                        $error("hit_total: expected %0d, got %0d", want.hit_total, o_hit_total);
                        err_count++;
                    end
                    if (o_miss_total !== want.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               want.miss_total, o_miss_total);
                        err_count++;
                    end
                end
                rx_count++;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (rx_count >= 100 && !held_first) begin
                held_first  = 1'b1;
                stall_left  = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (rx_count >= 350 && !held_second) begin
                held_second = 1'b1;
                stall_left  = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if ((rx_count / 40) % 3 != 0 && $urandom_range(0, 3) == 0) begin
                stall_left  = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial begin : access_side
        int              i;
        int              p;
        int              ways_eff;
        int              ibits_eff;
        int              pool_n;
        int              gap;
        int              ways_tbl [PHASES];
        int              ibits_tbl [PHASES];
        int              off_tbl [PHASES];
        logic [CFG_W-1:0] cen_data;
        logic [63:0]     a64;
        logic [63:0]     set_part;
        bit [ADDR_BITS-1:0] tag_pool [16];
        bit              burst;

        err_count  = 0;
        cfg_ways   = 4'd8;
        cfg_ibits  = 4'd6;
        cfg_offset = 4'd7;
        cfg_count  = 1'b0;
        access_tick = '0;
        hits_n     = '0;
        misses_n   = '0;

        plan = '{
            '{ROW_CFG, CFG_COUNT_EN,   4'd1,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h0,            1'b1, '{1'b0, 32'd0, 32'd1}},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h7F,           1'b1, '{1'b1, 32'd1, 32'd1}},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 32'd1, 32'd2}},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'hFFFF_FFFF_FF80, 1'b1, '{1'b1, 32'd2, 32'd2}},
            // a way count of zero acts as one way
            '{ROW_CFG, CFG_WAYS,       4'd0,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h0,            1'b1, '{1'b1, 32'd3, 32'd2}},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h2000,         1'b1, '{1'b0, 32'd3, 32'd3}},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h0,            1'b1, '{1'b0, 32'd3, 32'd4}},
            // two ways: refresh on hit, then evict the older line
            '{ROW_CFG, CFG_WAYS,       4'd2,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h2000,         1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h4000,         1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h2000,         1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h4000,         1'b0, '0},
            // way count above the maximum saturates
            '{ROW_CFG, CFG_WAYS,       4'd15, 48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h6000,         1'b0, '0},
            // index width above the maximum saturates, no offset
            '{ROW_CFG, CFG_INDEX_BITS, 4'd15, 48'h0,            1'b0, '0},
            '{ROW_CFG, CFG_OFFSET,     4'd0,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h3FF,          1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h8000_0000_03FF, 1'b0, '0},
            // widest offset with a single set
            '{ROW_CFG, CFG_OFFSET,     4'd15, 48'h0,            1'b0, '0},
            '{ROW_CFG, CFG_INDEX_BITS, 4'd0,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h7FFF,         1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h7FFF_FFFF_8000, 1'b0, '0},
            // counting off: totals freeze
            '{ROW_CFG, CFG_COUNT_EN,   4'd0,  48'h0,            1'b0, '0},
            '{ROW_ACC, CFG_WAYS,       4'd0,  48'h7FFF,         1'b0, '0}
        };

        ways_tbl  = '{1, 8, 0, 15, 4, 2, 8, 3, -1, -1};
        ibits_tbl = '{0, 10, 3, 15, 2, 1, 6, 4, -1, -1};
        off_tbl   = '{0, 12, 4, 15, 5, 3, 7, 2, -1, -1};

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_WAYS;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_address  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_block();
                write_reg(plan[i].reg_sel, plan[i].data);
            end else begin
                put_access(plan[i].addr, pick_gap(), plan[i].typed, plan[i].want);
            end
        end

        // Random phases: reuse a small tag pool over a few sets for hits and evictions
        for (p = 0; p < PHASES; p++) begin
            drain_block();
            cen_data = 4'($urandom_range(0, 15));
            if (p < 2) cen_data[0] = 1'b1;
            write_reg(CFG_WAYS, 4'(ways_tbl[p] < 0 ? $urandom_range(0, 15) : ways_tbl[p]));
            write_reg(CFG_INDEX_BITS,
                      4'(ibits_tbl[p] < 0 ? $urandom_range(0, 15) : ibits_tbl[p]));
            write_reg(CFG_OFFSET, 4'(off_tbl[p] < 0 ? $urandom_range(0, 15) : off_tbl[p]));
            write_reg(CFG_COUNT_EN, cen_data);

            ways_eff  = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);
            ibits_eff = (cfg_ibits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg_ibits;
            pool_n    = ways_eff + 2;
            for (i = 0; i < pool_n; i++) tag_pool[i] = ADDR_BITS'({$urandom(), $urandom()});
            burst = p[0];

            for (i = 0; i < PHASE_ITEMS; i++) begin
                a64 = {$urandom(), $urandom()};
                if ($urandom_range(0, 99) >= 15) begin
                    set_part = 64'($urandom_range(0, 3)) & ((64'd1 << ibits_eff) - 64'd1);
                    a64 = (64'(tag_pool[$urandom_range(0, pool_n - 1)])
                              << (cfg_offset + ibits_eff))
                          | (set_part << cfg_offset)
                          | (a64 & ((64'd1 << cfg_offset) - 64'd1));
                end
                gap = burst ? 0 : pick_gap();
                put_access(a64[ADDR_BITS-1:0], gap, 1'b0, '0);
            end
        end

        drain_block();
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ set_assoc_lru_cache_tags_core.f @@
+incdir+rtl
rtl/salc_pkg.sv
rtl/set_assoc_lru_cache_tags_core.sv
test/set_assoc_lru_cache_tags_core_tb.sv
